>>> design/pixel_replicating_upscaler_core_defines.svh
// Assertion macros shared by the upscaler modules.
// Each checker samples on the rising clock edge and is switched off while reset is low.
`ifndef PIXEL_REPLICATING_UPSCALER_CORE_DEFINES_SVH
`define PIXEL_REPLICATING_UPSCALER_CORE_DEFINES_SVH

`ifndef SYNTH

// A property that must hold at every clock edge.
`define PRUPSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define PRUPSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// An antecedent that implies a consequent in the following cycle.
`define PRUPSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define PRUPSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PRUPSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define PRUPSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/prupsc_pkg.sv
package prupsc_pkg;

	// Field and register widths fixed by the interface.
	localparam int COLOUR_W    = 8;
	localparam int SCALE_W     = 7;
	localparam int ROW_WIDTH_W = 12;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_INDEX_W = 1;
	localparam int PAD_W       = 2;

	// Operation codes of an input item.
	localparam logic OP_PIXEL  = 1'b0;
	localparam logic OP_REPLAY = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE     = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 1'b1;

	// One 24-bit pixel as held in the line buffer.
	typedef struct packed {
		logic [COLOUR_W-1:0] red;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] blue;
	} pixel_t;

	localparam int PIXEL_W = $bits(pixel_t);

	// Row-end marking that travels with an item to the output stage.
	typedef struct packed {
		logic             row_end;
		logic [PAD_W-1:0] pad;
	} row_tag_t;

endpackage

>>> design/pixel_replicating_upscaler_core.sv
// Channel   Handshake              Payload
// input     in_valid / in_stall    op, blue, green, red
// output    out_valid / out_stall  out_blue, out_green, out_red, row_end, pad_bytes, last
// config    cfg_we                 cfg_index, cfg_data
//
// Each accepted item that runs gives scale result items at the output register, one per cycle
// when not stalled; the next item enters it as the last copy leaves: one per cycle at scale 1.
// The first copy passes through stage one, then the output register.
// A replay reads the row store in the cycle of acceptance; its read data is ready in stage one.
// Reset clears the row position, the pass count, the pipeline flags and sets both registers to 1;
// the row store is not cleared. Items out of turn are accepted and dropped.
// A stalled output holds its copy; stage one then fills and in_stall rises.
module pixel_replicating_upscaler_core #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_SCALE = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [prupsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [prupsc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 op,
	input  logic [prupsc_pkg::COLOUR_W-1:0]      blue,
	input  logic [prupsc_pkg::COLOUR_W-1:0]      green,
	input  logic [prupsc_pkg::COLOUR_W-1:0]      red,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [prupsc_pkg::COLOUR_W-1:0]      out_blue,
	output logic [prupsc_pkg::COLOUR_W-1:0]      out_green,
	output logic [prupsc_pkg::COLOUR_W-1:0]      out_red,
	output logic                                 row_end,
	output logic [prupsc_pkg::PAD_W-1:0]         pad_bytes,
	output logic                                 last
);
	import prupsc_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int PW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

	pixel_t        pixel;
	logic          take;
	logic          valid_s1;
	logic          op_s1;
	pixel_t        pix_s1;
	row_tag_t      tag_s1;
	logic [PW-1:0] sm1_s1;
	logic          mem_we;
	logic          mem_re;
	logic [CW-1:0] mem_addr;
	pixel_t        mem_wdata;
	pixel_t        rd_data;

	// Gather the input colour bytes into one pixel.
	always_comb begin
		pixel.blue  = blue;
		pixel.green = green;
		pixel.red   = red;
	end

	// Sequencing, row position and stage one.
	prupsc_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_SCALE (MAX_SCALE),
		.CW        (CW),
		.PW        (PW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.pixel     (pixel),
		.take      (take),
		.valid_s1  (valid_s1),
		.op_s1     (op_s1),
		.pix_s1    (pix_s1),
		.tag_s1    (tag_s1),
		.sm1_s1    (sm1_s1),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata)
	);

	// Row store.
	prupsc_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (rd_data)
	);

	// Copy replication and output register.
	prupsc_emit #(
		.PW (PW)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.op_s1     (op_s1),
		.pix_s1    (pix_s1),
		.rd_data   (rd_data),
		.tag_s1    (tag_s1),
		.sm1_s1    (sm1_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_blue  (out_blue),
		.out_green (out_green),
		.out_red   (out_red),
		.row_end   (row_end),
		.pad_bytes (pad_bytes),
		.last      (last)
	);

endmodule

>>> design/prupsc_line_buf.sv
module prupsc_line_buf #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic                  re,
	input  logic [AW-1:0]         addr,
	input  prupsc_pkg::pixel_t    wdata,
	output prupsc_pkg::pixel_t    rdata
);
	import prupsc_pkg::*;

	pixel_t mem [DEPTH];
	pixel_t rdata_q;

	// Single-port row store: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/prupsc_front.sv
`include "pixel_replicating_upscaler_core_defines.svh"

module prupsc_front #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_SCALE = 64,
	parameter int CW        = 11,
	parameter int PW        = 6
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [prupsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [prupsc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   op,
	input  prupsc_pkg::pixel_t                     pixel,
	input  logic                                   take,
	output logic                                   valid_s1,
	output logic                                   op_s1,
	output prupsc_pkg::pixel_t                     pix_s1,
	output prupsc_pkg::row_tag_t                   tag_s1,
	output logic [PW-1:0]                          sm1_s1,
	output logic                                   mem_we,
	output logic                                   mem_re,
	output logic [CW-1:0]                          mem_addr,
	output prupsc_pkg::pixel_t                     mem_wdata
);
	import prupsc_pkg::*;

	localparam int XW = (CW + 1 > ROW_WIDTH_W) ? CW + 1 : ROW_WIDTH_W;

	logic [SCALE_W-1:0]     scale_q;
	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic [CW-1:0]          column_q;
	logic [PW-1:0]          passes_q;

	logic                   valid_s1_q;
	logic                   op_s1_q;
	pixel_t                 pix_s1_q;
	row_tag_t               tag_s1_q;
	logic [PW-1:0]          sm1_s1_q;

	logic [XW-1:0]          rw_x;
	logic [XW-1:0]          eff_w;
	logic [SCALE_W-1:0]     eff_s;
	logic [PW-1:0]          sm1;
	logic                   end_row;
	logic [3:0]             ws;
	logic [3:0]             ws3;
	logic [PAD_W-1:0]       pad;
	logic                   accept;
	logic                   run;

	// Clamp the registers to their working ranges.
	always_comb begin
		rw_x = XW'(row_width_q);
		if (rw_x == '0) begin
			eff_w = XW'(1);
		end else if (rw_x > XW'(MAX_WIDTH)) begin
			eff_w = XW'(MAX_WIDTH);
		end else begin
			eff_w = rw_x;
		end
		if (scale_q == '0) begin
			eff_s = SCALE_W'(1);
		end else if (scale_q > SCALE_W'(MAX_SCALE)) begin
			eff_s = SCALE_W'(MAX_SCALE);
		end else begin
			eff_s = scale_q;
		end
		sm1 = PW'(eff_s - SCALE_W'(1));
	end

	// Row end and padding: only the low two bits of width and scale matter modulo 4.
	always_comb begin
		end_row = (XW'(column_q) + XW'(1)) >= eff_w;
		ws      = 4'(eff_w[1:0]) * 4'(eff_s[1:0]);
		ws3     = 4'(ws * 4'd3);
		pad     = PAD_W'(2'd0 - ws3[1:0]);
	end

	// An item is taken whenever stage one is free or moves on; out-of-turn items vanish.
	assign in_stall = valid_s1_q && !take;
	assign accept   = in_valid && !in_stall;
	assign run      = accept && ((op == OP_PIXEL) ? (passes_q == '0) : (passes_q != '0));

	// The row store is written on a source pixel and read on a replay step.
	// A replay always comes after the write of its entry.
	assign mem_we    = run && (op == OP_PIXEL);
	assign mem_re    = run && (op == OP_REPLAY);
	assign mem_addr  = column_q;
	assign mem_wdata = pixel;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_W'(1);
			row_width_q <= ROW_WIDTH_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE:     scale_q     <= cfg_data[SCALE_W-1:0];
				REG_ROW_WIDTH: row_width_q <= cfg_data[ROW_WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Row position and replay pass count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			passes_q <= '0;
		end else if (run) begin
			if (end_row) begin
				column_q <= '0;
				passes_q <= (op == OP_PIXEL) ? sm1 : PW'(passes_q - PW'(1));
			end else begin
				column_q <= CW'(column_q + CW'(1));
			end
		end
	end

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (run) begin
			valid_s1_q <= 1'b1;
		end else if (take) begin
			valid_s1_q <= 1'b0;
		end
	end

	// Stage one payload, held while the output stage is busy.
	always_ff @(posedge clk) begin
		if (run) begin
			op_s1_q          <= op;
			pix_s1_q         <= pixel;
			tag_s1_q.row_end <= end_row;
			tag_s1_q.pad     <= pad;
			sm1_s1_q         <= sm1;
		end
	end

	assign valid_s1 = valid_s1_q;
	assign op_s1    = op_s1_q;
	assign pix_s1   = pix_s1_q;
	assign tag_s1   = tag_s1_q;
	assign sm1_s1   = sm1_s1_q;

	`PRUPSC_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1_q && !take, valid_s1_q && $stable(pix_s1_q), "stage one item lost or changed while waiting")
	`PRUPSC_ASSERT_NEXT(a_write_loads_s1, clk, arst_n, mem_we, valid_s1_q && (op_s1_q == OP_PIXEL), "row store written without a source item in stage one")
	`PRUPSC_ASSERT_IMPL(a_no_write_in_replay, clk, arst_n, passes_q != '0, !mem_we, "row store overwritten while replay passes are owed")

endmodule

>>> design/prupsc_emit.sv
`include "pixel_replicating_upscaler_core_defines.svh"

module prupsc_emit #(
	parameter int PW = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s1,
	input  logic                              op_s1,
	input  prupsc_pkg::pixel_t                pix_s1,
	input  prupsc_pkg::pixel_t                rd_data,
	input  prupsc_pkg::row_tag_t              tag_s1,
	input  logic [PW-1:0]                     sm1_s1,
	output logic                              take,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [prupsc_pkg::COLOUR_W-1:0]   out_blue,
	output logic [prupsc_pkg::COLOUR_W-1:0]   out_green,
	output logic [prupsc_pkg::COLOUR_W-1:0]   out_red,
	output logic                              row_end,
	output logic [prupsc_pkg::PAD_W-1:0]      pad_bytes,
	output logic                              last
);
	import prupsc_pkg::*;

	logic          out_valid_q;
	logic [PW-1:0] cnt_q;
	pixel_t        pix_q;
	row_tag_t      tag_q;
	logic [PW-1:0] sm1_q;

	logic          fire;
	logic          fin;
	logic          done;

	// A copy leaves on each unstalled cycle; the item is finished after its last copy.
	assign fire = out_valid_q && !out_stall;
	assign fin  = (cnt_q == sm1_q);
	assign done = fire && fin;
	assign take = valid_s1 && (!out_valid_q || done);

	// Output valid flag and copy counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (take) begin
			out_valid_q <= 1'b1;
			cnt_q       <= '0;
		end else if (done) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			cnt_q <= PW'(cnt_q + PW'(1));
		end
	end

	// Output payload: a replay takes its pixel from the row store read data.
	always_ff @(posedge clk) begin
		if (take) begin
			pix_q <= (op_s1 == OP_REPLAY) ? rd_data : pix_s1;
			tag_q <= tag_s1;
			sm1_q <= sm1_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_blue  = pix_q.blue;
	assign out_green = pix_q.green;
	assign out_red   = pix_q.red;
	assign last      = fin;
	assign row_end   = fin && tag_q.row_end;
	assign pad_bytes = (fin && tag_q.row_end) ? tag_q.pad : '0;

	`PRUPSC_ASSERT_IMPL(a_cnt_range, clk, arst_n, out_valid_q, cnt_q <= sm1_q, "copy counter ran past the scale")
	`PRUPSC_ASSERT_IMPL(a_row_end_last, clk, arst_n, out_valid_q && row_end, last, "row end marked on a copy that is not the last")
	`PRUPSC_ASSERT_IMPL(a_pad_only_at_end, clk, arst_n, out_valid_q, (pad_bytes == '0) || row_end, "padding reported away from a row end")

endmodule
